>>> src/smmu_pkg.sv
// Shared types, constants and inversion chain tables of the scalar Montgomery unit.
package smmu_pkg;

    localparam int OPER_W      = 256;
    localparam int QUEUE_DEPTH = 2;
    localparam int MEM_DEPTH   = 10;
    localparam int SLOT_W      = $clog2(MEM_DEPTH);
    localparam int CHAIN_STEPS = 27;
    localparam int PRE_OPS     = 9;

    localparam logic [OPER_W-1:0] ORDER_L = {
        64'h1000000000000000, 64'h0000000000000000,
        64'h14DEF9DEA2F79CD6, 64'h5812631A5CF5D3ED};
    localparam logic [OPER_W-1:0] R2_MOD_L = {
        64'h0399411B7C309A3D, 64'hCEEC73D217F5BE65,
        64'hD00E1BA768859347, 64'hA40611E3449C0F01};

    localparam logic [2:0] CMD_MUL  = 3'd0;
    localparam logic [2:0] CMD_SQR  = 3'd1;
    localparam logic [2:0] CMD_TO   = 3'd2;
    localparam logic [2:0] CMD_FROM = 3'd3;
    localparam logic [2:0] CMD_INV  = 3'd4;

    // Register file slots: 0..6 odd powers, then x^2, x^4 and the accumulator.
    localparam logic [SLOT_W-1:0] SLOT_P0  = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_X2  = SLOT_W'(7);
    localparam logic [SLOT_W-1:0] SLOT_X4  = SLOT_W'(8);
    localparam logic [SLOT_W-1:0] SLOT_ACC = SLOT_W'(9);

    typedef enum logic [1:0] {K_MUL, K_INV, K_ZERO} t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [OPER_W-1:0] a;
        logic [OPER_W-1:0] b;
    } t_job;

    typedef struct packed {
        logic [SLOT_W-1:0] dst;
        logic [SLOT_W-1:0] sa;
        logic [SLOT_W-1:0] sb;
    } t_op;

    typedef enum logic [2:0] {M_IDLE, M_PREP, M_LOOP, M_FIN, M_DONE} t_mstate;
    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_READ, S_RUN, S_DONE} t_bstate;

    function automatic t_op pre_op(input logic [3:0] idx);
        t_op op;
        case (idx)
            4'd0:    op = '{SLOT_X2, SLOT_P0, SLOT_P0};
            4'd1:    op = '{SLOT_X4, SLOT_X2, SLOT_X2};
            4'd2:    op = '{SLOT_W'(1), SLOT_X2, SLOT_P0};
            4'd3:    op = '{SLOT_W'(2), SLOT_X2, SLOT_W'(1)};
            4'd4:    op = '{SLOT_W'(3), SLOT_X2, SLOT_W'(2)};
            4'd5:    op = '{SLOT_W'(4), SLOT_X2, SLOT_W'(3)};
            4'd6:    op = '{SLOT_W'(5), SLOT_X2, SLOT_W'(4)};
            4'd7:    op = '{SLOT_W'(6), SLOT_X4, SLOT_W'(5)};
            4'd8:    op = '{SLOT_ACC, SLOT_P0, SLOT_W'(6)};
            default: op = '{SLOT_ACC, SLOT_ACC, SLOT_ACC};
        endcase
        return op;
    endfunction

    function automatic logic [6:0] chain_sqr(input logic [4:0] s);
        logic [6:0] n;
        case (s)
            5'd0:  n = 7'd126; 5'd1:  n = 7'd4;  5'd2:  n = 7'd5;  5'd3:  n = 7'd5;
            5'd4:  n = 7'd4;   5'd5:  n = 7'd2;  5'd6:  n = 7'd5;  5'd7:  n = 7'd4;
            5'd8:  n = 7'd6;   5'd9:  n = 7'd3;  5'd10: n = 7'd5;  5'd11: n = 7'd5;
            5'd12: n = 7'd4;   5'd13: n = 7'd5;  5'd14: n = 7'd6;  5'd15: n = 7'd10;
            5'd16: n = 7'd4;   5'd17: n = 7'd5;  5'd18: n = 7'd5;  5'd19: n = 7'd5;
            5'd20: n = 7'd4;   5'd21: n = 7'd6;  5'd22: n = 7'd5;  5'd23: n = 7'd3;
            5'd24: n = 7'd6;   5'd25: n = 7'd3;  5'd26: n = 7'd3;
            default: n = 7'd0;
        endcase
        return n;
    endfunction

    function automatic logic [SLOT_W-1:0] chain_mul(input logic [4:0] s);
        logic [2:0] m;
        case (s)
            5'd0:  m = 3'd2; 5'd1:  m = 3'd1; 5'd2:  m = 3'd6; 5'd3:  m = 3'd6;
            5'd4:  m = 3'd4; 5'd5:  m = 3'd1; 5'd6:  m = 3'd6; 5'd7:  m = 3'd2;
            5'd8:  m = 3'd2; 5'd9:  m = 3'd3; 5'd10: m = 3'd6; 5'd11: m = 3'd3;
            5'd12: m = 3'd1; 5'd13: m = 3'd5; 5'd14: m = 3'd5; 5'd15: m = 3'd4;
            5'd16: m = 3'd1; 5'd17: m = 3'd1; 5'd18: m = 3'd1; 5'd19: m = 3'd4;
            5'd20: m = 3'd3; 5'd21: m = 3'd6; 5'd22: m = 3'd5; 5'd23: m = 3'd2;
            5'd24: m = 3'd6; 5'd25: m = 3'd2; 5'd26: m = 3'd1;
            default: m = 3'd0;
        endcase
        return SLOT_W'(m);
    endfunction

endpackage

>>> src/smmu_queue.sv
// Small synchronous FIFO with push/full and pop/empty sides.
module smmu_queue #(
    parameter type T     = logic,
    parameter int  Depth = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    T              r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    logic            w_wr, w_rd;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (w_rd) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + PtrW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end
endmodule

>>> src/smmu_front.sv
// Command decode: turn an input item into a multiply, invert or zero job.
module smmu_front (
    input  logic [2:0]              i_command,
    input  logic [smmu_pkg::OPER_W-1:0] i_a,
    input  logic [smmu_pkg::OPER_W-1:0] i_b,
    output smmu_pkg::t_job          o_job
);
    import smmu_pkg::*;

    always_comb begin
        o_job.a    = i_a;
        o_job.b    = i_b;
        o_job.kind = K_MUL;
        case (i_command)
            CMD_MUL:  o_job.b = i_b;
            CMD_SQR:  o_job.b = i_a;
            CMD_TO:   o_job.b = R2_MOD_L;
            CMD_FROM: o_job.b = OPER_W'(1);
            CMD_INV:  o_job.kind = K_INV;
            default:  o_job.kind = K_ZERO;
        endcase
    end
endmodule

>>> src/smmu_mont.sv
// Radix-2 Montgomery multiplier: a*b/2^256 with one final subtraction of l.
module smmu_mont (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [smmu_pkg::OPER_W-1:0] i_a,
    input  logic [smmu_pkg::OPER_W-1:0] i_b,
    output logic                        o_done,
    output logic [smmu_pkg::OPER_W-1:0] o_res
);
    import smmu_pkg::*;

    localparam int CntW = $clog2(OPER_W);

    t_mstate           r_state, n_state;
    logic [OPER_W-1:0] r_a, r_b, r_res;
    logic [OPER_W:0]   r_bl, r_t, w_add;
    logic [OPER_W+1:0] w_sum, w_diff;
    logic [CntW-1:0]   r_cnt;
    logic              w_q;

    // quotient bit makes the sum even
    assign w_q = r_t[0] ^ (r_a[0] & r_b[0]);

    always_comb begin
        case ({w_q, r_a[0]})
            2'b01:   w_add = {1'b0, r_b};
            2'b10:   w_add = {1'b0, ORDER_L};
            2'b11:   w_add = r_bl;
            default: w_add = '0;
        endcase
    end

    assign w_sum  = {1'b0, r_t} + {1'b0, w_add};
    assign w_diff = {1'b0, r_t} - {2'b00, ORDER_L};

    always_comb begin
        n_state = r_state;
        case (r_state)
            M_IDLE:  if (i_start) n_state = M_PREP;
            M_PREP:  n_state = M_LOOP;
            M_LOOP:  if (r_cnt == CntW'(OPER_W - 1)) n_state = M_FIN;
            M_FIN:   n_state = M_DONE;
            M_DONE:  n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == M_DONE);
        o_res  = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    r_a   <= i_a;
                    r_b   <= i_b;
                    r_t   <= '0;
                    r_cnt <= '0;
                end
            end
            M_PREP: r_bl <= {1'b0, r_b} + {1'b0, ORDER_L};
            M_LOOP: begin
                r_t   <= w_sum[OPER_W+1:1];
                r_a   <= r_a >> 1;
                r_cnt <= r_cnt + CntW'(1);
            end
            M_FIN:  r_res <= w_diff[OPER_W+1] ? r_t[OPER_W-1:0] : w_diff[OPER_W-1:0];
            default: ;
        endcase
    end
endmodule

>>> src/smmu_back.sv
// Job execution: single products, zero results and the inversion addition chain.
module smmu_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  smmu_pkg::t_job              i_job,
    input  logic                        i_job_empty,
    output logic                        o_job_pop,
    output logic                        o_res_push,
    output logic [smmu_pkg::OPER_W-1:0] o_res,
    input  logic                        i_res_full
);
    import smmu_pkg::*;

    t_bstate           r_state, n_state;
    t_kind             r_kind;
    logic [OPER_W-1:0] r_mem [MEM_DEPTH];
    logic [OPER_W-1:0] r_rd_a, r_rd_b, r_res;
    logic              r_pre;
    logic [3:0]        r_pidx;
    logic [4:0]        r_step;
    logic [6:0]        r_k;
    t_op               w_op;
    logic              w_start, w_done, w_last, w_we;
    logic [SLOT_W-1:0] w_wa;
    logic [OPER_W-1:0] w_wd, w_ea, w_eb, w_eres;

    always_comb begin
        if (r_pre) begin
            w_op = pre_op(r_pidx);
        end else if (r_k < chain_sqr(r_step)) begin
            w_op = '{SLOT_ACC, SLOT_ACC, SLOT_ACC};
        end else begin
            w_op = '{SLOT_ACC, SLOT_ACC, chain_mul(r_step)};
        end
    end

    assign w_last = !r_pre && (r_k >= chain_sqr(r_step))
                    && (r_step == 5'(CHAIN_STEPS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    case (i_job.kind)
                        K_MUL:   n_state = S_RUN;
                        K_INV:   n_state = S_FETCH;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_FETCH: n_state = S_READ;
            S_READ:  n_state = S_RUN;
            S_RUN: begin
                if (w_done) begin
                    n_state = (r_kind == K_INV && !w_last) ? S_FETCH : S_DONE;
                end
            end
            S_DONE:  if (!i_res_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop  = (r_state == S_IDLE) && !i_job_empty;
        o_res_push = (r_state == S_DONE);
        o_res      = r_res;
        w_start    = (r_state == S_READ)
                     || (o_job_pop && i_job.kind == K_MUL);
        w_ea       = (r_state == S_READ) ? r_rd_a : i_job.a;
        w_eb       = (r_state == S_READ) ? r_rd_b : i_job.b;
        w_we       = 1'b0;
        w_wa       = SLOT_P0;
        w_wd       = i_job.a;
        if (o_job_pop && i_job.kind == K_INV) begin
            w_we = 1'b1;
        end else if (r_state == S_RUN && w_done && r_kind == K_INV) begin
            w_we = 1'b1;
            w_wa = w_op.dst;
            w_wd = w_eres;
        end
    end

    smmu_mont u_mont (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_ea),
        .i_b     (w_eb),
        .o_done  (w_done),
        .o_res   (w_eres)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (r_state == S_FETCH) begin
            r_rd_a <= r_mem[w_op.sa];
            r_rd_b <= r_mem[w_op.sb];
        end
        if (o_job_pop) begin
            r_res <= '0;
        end else if (r_state == S_RUN && w_done) begin
            r_res <= w_eres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_ZERO;
            r_pre   <= 1'b1;
            r_pidx  <= '0;
            r_step  <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (o_job_pop) begin
                r_kind <= i_job.kind;
                r_pre  <= 1'b1;
                r_pidx <= '0;
                r_step <= '0;
                r_k    <= '0;
            end else if (r_state == S_RUN && w_done && r_kind == K_INV) begin
                if (r_pre) begin
                    if (r_pidx == 4'(PRE_OPS - 1)) begin
                        r_pre <= 1'b0;
                    end else begin
                        r_pidx <= r_pidx + 4'd1;
                    end
                end else if (r_k < chain_sqr(r_step)) begin
                    r_k <= r_k + 7'd1;
                end else begin
                    r_step <= r_step + 5'd1;
                    r_k    <= '0;
                end
            end
        end
    end
endmodule

>>> src/scalar_montgomery_mod_order_unit_core.sv
// Top level of the Montgomery arithmetic unit modulo the group order l.
// Multiply, square and both conversions each run one product through the radix-2
// Montgomery loop (256 iterations, setup, final subtract), between the job pop and
// the hand-off into the result queue.
// Invert runs 284 products, each with its own operand fetch.
// One job is worked on at a time; queues on both sides decouple transfers in and out.
// Synchronous active-low reset empties both queues and idles sequencer and multiplier.
module scalar_montgomery_mod_order_unit_core #(
    parameter int QueueDepth = smmu_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_command,
    input  logic [63:0] i_a_limb0,
    input  logic [63:0] i_a_limb1,
    input  logic [63:0] i_a_limb2,
    input  logic [63:0] i_a_limb3,
    input  logic [63:0] i_b_limb0,
    input  logic [63:0] i_b_limb1,
    input  logic [63:0] i_b_limb2,
    input  logic [63:0] i_b_limb3,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_result_limb0,
    output logic [63:0] o_result_limb1,
    output logic [63:0] o_result_limb2,
    output logic [63:0] o_result_limb3
);
    import smmu_pkg::*;

    t_job              w_dec, w_job;
    logic              w_job_empty, w_job_pop, w_res_push, w_res_full;
    logic [OPER_W-1:0] w_res, w_out;

    // decode the command into a product, chain or zero job
    smmu_front u_front (
        .i_command (i_command),
        .i_a       ({i_a_limb3, i_a_limb2, i_a_limb1, i_a_limb0}),
        .i_b       ({i_b_limb3, i_b_limb2, i_b_limb1, i_b_limb0}),
        .o_job     (w_dec)
    );

    // hold decoded jobs so the input side can keep taking transfers
    smmu_queue #(.T(t_job), .Depth(QueueDepth)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_dec),
        .o_full  (full),
        .i_pop   (w_job_pop),
        .o_data  (w_job),
        .o_empty (w_job_empty)
    );

    smmu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job),
        .i_job_empty (w_job_empty),
        .o_job_pop   (w_job_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    // results wait here until popped
    smmu_queue #(.T(logic [OPER_W-1:0]), .Depth(QueueDepth)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_out),
        .o_empty (empty)
    );

    assign o_result_limb0 = w_out[63:0];
    assign o_result_limb1 = w_out[127:64];
    assign o_result_limb2 = w_out[191:128];
    assign o_result_limb3 = w_out[255:192];
endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench of the scalar Montgomery unit working modulo the group order l.

// Scoreboard: predicts each result from its operands in 256-bit Montgomery arithmetic
// and holds the expected results in arrival order.
class order_product_board;

    localparam logic [255:0] ORD_L = {
        64'h1000000000000000, 64'h0000000000000000,
        64'h14DEF9DEA2F79CD6, 64'h5812631A5CF5D3ED};
    localparam logic [255:0] R_SQ_MOD_L = {
        64'h0399411B7C309A3D, 64'hCEEC73D217F5BE65,
        64'hD00E1BA768859347, 64'hA40611E3449C0F01};
    localparam logic [255:0] MINUS_L_INV = {
        64'h9DB6C6F26FE91836, 64'h14E75438FFA36BEA,
        64'hB1A206F2FDBA84FF, 64'hD2B51DA312547E1B};

    logic [255:0] expected_results[$];
    int           mismatches;

    function new();
        mismatches = 0;
    endfunction

    // One Montgomery reduction of a 512-bit product, with a single conditional subtract.
    function automatic logic [255:0] reduce(input logic [511:0] p);
        logic [255:0] q;
        logic [512:0] t;
        logic [256:0] hi;
        q  = p[255:0] * MINUS_L_INV;
        t  = {1'b0, p} + 513'(q) * 513'(ORD_L);
        hi = t[512:256];
        if (hi >= 257'(ORD_L)) begin
            return 256'(hi - 257'(ORD_L));
        end
        return hi[255:0];
    endfunction

    function automatic logic [255:0] mont_product(input logic [255:0] x, input logic [255:0] y);
        return reduce(512'(x) * 512'(y));
    endfunction

    // Raise x to l-2 by the fixed window chain: squarings then a multiply by an odd power.
    function automatic logic [255:0] mont_inverse(input logic [255:0] x);
        int           sq_runs[27] = '{126, 4, 5, 5, 4, 2, 5, 4, 6, 3, 5, 5, 4, 5, 6, 10,
                                      4, 5, 5, 5, 4, 6, 5, 3, 6, 3, 3};
        int           pw_sel[27]  = '{2, 1, 6, 6, 4, 1, 6, 2, 2, 3, 6, 3, 1, 5, 5, 4,
                                      1, 1, 1, 4, 3, 6, 5, 2, 6, 2, 1};
        logic [255:0] odd_pw[7];
        logic [255:0] x2, x4, acc;
        odd_pw[0] = x;
        x2 = mont_product(x, x);
        x4 = mont_product(x2, x2);
        for (int k = 1; k < 6; k++) begin
            odd_pw[k] = mont_product(x2, odd_pw[k-1]);
        end
        odd_pw[6] = mont_product(x4, odd_pw[5]);
        acc = mont_product(odd_pw[0], odd_pw[6]);
        for (int s = 0; s < 27; s++) begin
            for (int k = 0; k < sq_runs[s]; k++) begin
                acc = mont_product(acc, acc);
            end
            acc = mont_product(acc, odd_pw[pw_sel[s]]);
        end
        return acc;
    endfunction

    function void note_operands(input logic [2:0] cmd, input logic [255:0] a,
                                input logic [255:0] b);
        logic [255:0] r;
        case (cmd)
            smmu_pkg::CMD_MUL:  r = mont_product(a, b);
            smmu_pkg::CMD_SQR:  r = mont_product(a, a);
            smmu_pkg::CMD_TO:   r = mont_product(a, R_SQ_MOD_L);
            smmu_pkg::CMD_FROM: r = reduce(512'(a));
            smmu_pkg::CMD_INV:  r = mont_inverse(a);
            default:            r = '0;
        endcase
        expected_results.push_back(r);
    endfunction

    function void check_result(input logic [255:0] got);
        logic [255:0] want;
        if (expected_results.size() == 0) begin
            $display("%0t: result %h arrived with nothing expected", $time, got);
            mismatches++;
            return;
        end
        want = expected_results.pop_front();
        for (int k = 0; k < 4; k++) begin
            if (got[64*k +: 64] !== want[64*k +: 64]) begin
                $display("%0t: result_limb%0d expected %h actual %h",
                         $time, k, want[64*k +: 64], got[64*k +: 64]);
                mismatches++;
            end
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smmu_pkg::*;

    localparam logic [255:0] L_VAL   = {64'h1000000000000000, 64'h0000000000000000,
                                        64'h14DEF9DEA2F79CD6, 64'h5812631A5CF5D3ED};
    localparam logic [255:0] ALL_ONE = '1;
    localparam longint CYCLE_LIMIT   = 64'd8_000_000;
    localparam int RAND_ITEMS        = 1150;
    localparam int MAX_RAND_INV      = 2;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [2:0]  i_command;
    logic [63:0] i_a_limb0, i_a_limb1, i_a_limb2, i_a_limb3;
    logic [63:0] i_b_limb0, i_b_limb1, i_b_limb2, i_b_limb3;
    logic        empty;
    logic        pop;
    logic [63:0] o_result_limb0, o_result_limb1, o_result_limb2, o_result_limb3;

    order_product_board board = new();

    int     tx_idle_pct;
    int     rx_idle_pct;
    bit     hold_req;
    int     hold_left;
    longint cycles;

    scalar_montgomery_mod_order_unit_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_a_limb0      (i_a_limb0),
        .i_a_limb1      (i_a_limb1),
        .i_a_limb2      (i_a_limb2),
        .i_a_limb3      (i_a_limb3),
        .i_b_limb0      (i_b_limb0),
        .i_b_limb1      (i_b_limb1),
        .i_b_limb2      (i_b_limb2),
        .i_b_limb3      (i_b_limb3),
        .empty          (empty),
        .pop            (pop),
        .o_result_limb0 (o_result_limb0),
        .o_result_limb1 (o_result_limb1),
        .o_result_limb2 (o_result_limb2),
        .o_result_limb3 (o_result_limb3)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a run past the limit means the block hung somewhere.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("scalar_montgomery_mod_order_unit_core verification failed");
            $finish;
        end
    end

    // Result side: check each transfer out against the oldest expectation, then
    // pick pop for the next cycle. A hold request keeps pop low for a long run so
    // the result queue fills, the block backs up and full rises on the input side.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            board.check_result({o_result_limb3, o_result_limb2,
                                o_result_limb1, o_result_limb0});
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Operand mix: mostly full-width random, plus small values, values near l, values
    // reduced below l and values at the top of the 256-bit range.
    function automatic logic [255:0] rand_operand();
        logic [255:0] v;
        v = {rand64(), rand64(), rand64(), rand64()};
        case ($urandom_range(9))
            0: v = 256'(v[15:0]);
            1: v = L_VAL - 256'($urandom_range(3)) + 256'($urandom_range(3));
            2: v = ALL_ONE - 256'($urandom_range(255));
            3: v = v % L_VAL;
            default: ;
        endcase
        return v;
    endfunction

    // Offer one item; hold push and the fields until the transfer in happens.
    task automatic send_item(input logic [2:0] cmd, input logic [255:0] a,
                             input logic [255:0] b);
        if ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_command <= cmd;
        {i_a_limb3, i_a_limb2, i_a_limb1, i_a_limb0} <= a;
        {i_b_limb3, i_b_limb2, i_b_limb1, i_b_limb0} <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_operands(cmd, a, b);
    endtask

    task automatic send_random(input int count, inout int inv_used);
        logic [2:0] cmd;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7: cmd = CMD_MUL;
                8, 9, 10:               cmd = CMD_SQR;
                11, 12, 13:             cmd = CMD_TO;
                14, 15, 16:             cmd = CMD_FROM;
                17:                     cmd = 3'($urandom_range(5, 7));
                default: begin
                    // inversion runs 284 products; keep it rare
                    if (inv_used < MAX_RAND_INV && $urandom_range(199) == 0) begin
                        cmd = CMD_INV;
                        inv_used++;
                    end else begin
                        cmd = CMD_MUL;
                    end
                end
            endcase
            send_item(cmd, rand_operand(), rand_operand());
        end
    endtask

    initial begin
        int inv_used;
        inv_used    = 0;
        cycles      = 0;
        hold_req    = 1'b0;
        hold_left   = 0;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_command   = CMD_MUL;
        {i_a_limb3, i_a_limb2, i_a_limb1, i_a_limb0} = '0;
        {i_b_limb3, i_b_limb2, i_b_limb1, i_b_limb0} = '0;
        tx_idle_pct = 11;
        rx_idle_pct = 88;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: operand extremes, every command, unused codes, inverse of zero,
        // operands at and above l.
        send_item(CMD_MUL,  '0, '0);
        send_item(CMD_MUL,  ALL_ONE, ALL_ONE);
        send_item(CMD_MUL,  L_VAL - 1, 256'(1));
        send_item(CMD_MUL,  L_VAL, L_VAL);
        send_item(CMD_MUL,  ALL_ONE, 256'(1));
        send_item(CMD_SQR,  ALL_ONE, '0);
        send_item(CMD_SQR,  L_VAL - 1, ALL_ONE);
        send_item(CMD_TO,   ALL_ONE, '0);
        send_item(CMD_TO,   256'(1), '0);
        send_item(CMD_FROM, ALL_ONE, '0);
        send_item(CMD_FROM, 256'(1), ALL_ONE);
        send_item(CMD_FROM, L_VAL, '0);
        send_item(CMD_INV,  '0, '0);
        send_item(CMD_INV,  rand_operand() % L_VAL, '0);
        send_item(3'd5,     ALL_ONE, ALL_ONE);
        send_item(3'd6,     ALL_ONE, '0);
        send_item(3'd7,     rand_operand(), rand_operand());
        send_item(CMD_MUL,  rand_operand(), rand_operand());

        send_random(RAND_ITEMS / 3, inv_used);
        tx_idle_pct = 88;
        rx_idle_pct = 11;
        send_random(RAND_ITEMS / 3, inv_used);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // stall the result side while the sender keeps pushing
        hold_req = 1'b1;
        send_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3), inv_used);
        push <= 1'b0;

        // Drain, then wait for any stray result before the verdict.
        while (board.pending() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);

        if (board.mismatches == 0) begin
            $display("scalar_montgomery_mod_order_unit_core verification clean");
        end else begin
            $display("scalar_montgomery_mod_order_unit_core verification failed");
        end
        $finish;
    end

endmodule
